### design/fsc_pkg.sv
package fsc_pkg;

	localparam int SLOT_COUNT = 32;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CMD_W      = 2;
	localparam int TAG_W      = 15;
	localparam int SLOT_OUT_W = 5;

	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_INVAL  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic compare;
		logic commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

### design/fsc_ctrl.sv
module fsc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  fsc_pkg::dp_sts_t sts,
	output fsc_pkg::dp_cmd_t dp_cmd
);
	import fsc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_RES  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d        = state_q;
		dp_cmd.load    = 1'b0;
		dp_cmd.compare = 1'b0;
		dp_cmd.commit  = 1'b0;
		in_stall       = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					dp_cmd.load = 1'b1;
					state_d     = ST_CMP;
				end
			end
			ST_CMP: begin
				dp_cmd.compare = 1'b1;
				state_d        = ST_RES;
			end
			ST_RES: begin
				if (sts.out_free) begin
					dp_cmd.commit = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/fsc_dp.sv
module fsc_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fsc_pkg::dp_cmd_t               dp_cmd,
	output fsc_pkg::dp_sts_t               sts,
	input  logic [fsc_pkg::CMD_W-1:0]      cmd,
	input  logic [fsc_pkg::TAG_W-1:0]      anim_number,
	input  logic [fsc_pkg::TAG_W-1:0]      frame_number,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [fsc_pkg::SLOT_OUT_W-1:0] slot,
	output logic                           hit,
	output logic                           full_res
);
	import fsc_pkg::*;

	logic [TAG_W-1:0]      anim_tag_q  [SLOT_COUNT];
	logic [TAG_W-1:0]      frame_tag_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] mark_q;
	logic [SLOT_W-1:0]     ptr_q;

	logic [CMD_W-1:0]      cmd_q;
	logic [TAG_W-1:0]      anim_q;
	logic [TAG_W-1:0]      frame_q;

	logic [SLOT_COUNT-1:0] hit_vec_s1;
	logic [SLOT_COUNT-1:0] anim_vec_s1;

	logic                  out_valid_q;
	logic [SLOT_OUT_W-1:0] slot_q;
	logic                  hit_q;
	logic                  full_q;

	logic [SLOT_W-1:0]     hit_idx;
	logic [SLOT_W-1:0]     free_idx;
	logic [SLOT_W-1:0]     wrap_idx;
	logic                  any_hit;
	logic                  any_free;
	logic                  any_upper;
	logic [SLOT_COUNT-1:0] free_vec;
	logic [SLOT_COUNT-1:0] upper_vec;
	logic [SLOT_W-1:0]     res_idx;
	logic [SLOT_W+SLOT_OUT_W-1:0] res_ext;
	logic                  do_alloc;
	logic                  do_hit;
	logic                  do_full;

	assign sts.out_free = !out_valid_q || !out_stall;

	// lowest hit, and first free slot searched circularly from the pointer
	always_comb begin
		hit_idx   = '0;
		wrap_idx  = '0;
		free_idx  = '0;
		free_vec  = ~mark_q;
		upper_vec = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			upper_vec[i] = free_vec[i] && (SLOT_W'(i) >= ptr_q);
			if (hit_vec_s1[i]) begin
				hit_idx = SLOT_W'(i);
			end
			if (free_vec[i]) begin
				wrap_idx = SLOT_W'(i);
			end
		end
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (upper_vec[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
		any_hit   = |hit_vec_s1;
		any_free  = |free_vec;
		any_upper = |upper_vec;
		if (!any_upper) begin
			free_idx = wrap_idx;
		end
	end

	assign do_hit   = (cmd_q == CMD_LOOKUP) && any_hit;
	assign do_alloc = (cmd_q == CMD_LOOKUP) && !any_hit && any_free;
	assign do_full  = (cmd_q == CMD_LOOKUP) && !any_hit && !any_free;

	always_comb begin
		res_idx = '0;
		if (do_hit) begin
			res_idx = hit_idx;
		end else if (do_alloc) begin
			res_idx = free_idx;
		end
	end

	assign res_ext = {{SLOT_OUT_W{1'b0}}, res_idx};

	// request capture and tag compare
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			cmd_q   <= cmd;
			anim_q  <= anim_number;
			frame_q <= frame_number;
		end
		if (dp_cmd.compare) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				anim_vec_s1[i] <= (anim_tag_q[i] == anim_q);
				hit_vec_s1[i]  <= (anim_tag_q[i] == anim_q) && (frame_tag_q[i] == frame_q);
			end
		end
	end

	// slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				anim_tag_q[i]  <= '0;
				frame_tag_q[i] <= '0;
			end
			mark_q <= '0;
			ptr_q  <= '0;
		end else if (dp_cmd.commit) begin
			case (cmd_q)
				CMD_LOOKUP: begin
					if (do_hit) begin
						mark_q[hit_idx] <= 1'b1;
					end else if (do_alloc) begin
						anim_tag_q[free_idx]  <= anim_q;
						frame_tag_q[free_idx] <= frame_q;
						mark_q[free_idx]      <= 1'b1;
						ptr_q <= (free_idx == SLOT_W'(SLOT_COUNT - 1)) ? '0
							: free_idx + SLOT_W'(1);
					end
				end
				CMD_CLEAR: begin
					mark_q <= '0;
				end
				CMD_INVAL: begin
					for (int i = 0; i < SLOT_COUNT; i++) begin
						if (anim_vec_s1[i]) begin
							anim_tag_q[i]  <= '0;
							frame_tag_q[i] <= '0;
							mark_q[i]      <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.commit) begin
			slot_q <= res_ext[SLOT_OUT_W-1:0];
			hit_q  <= do_hit;
			full_q <= do_full;
		end
	end

	assign out_valid = out_valid_q;
	assign slot      = slot_q;
	assign hit       = hit_q;
	assign full_res  = full_q;

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.commit |-> sts.out_free)
		else $error("commit while output word still held");

	a_hit_or_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit_q && full_q))
		else $error("result flags both hit and full");

	a_hit_keeps_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.commit && do_hit) |=> $stable(ptr_q))
		else $error("pointer moved on a hit");

	a_clear_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.commit && (cmd_q == CMD_CLEAR)) |=> (mark_q == '0))
		else $error("marks left after clear");

	a_full_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.commit && do_full) |=> ($stable(mark_q) && $stable(ptr_q)))
		else $error("state changed on a full miss");

endmodule

### design/frame_slot_cache.sv
// fully associative cache of SLOT_COUNT slots tagged by animation and frame number, each
// with an in-use mark and a shared round-robin pointer. cmd 0 looks up a frame: a hit
// returns the lowest matching slot and marks it; a miss takes the first unmarked slot at or
// after the pointer (wrapping), writes its tags, marks it and moves the pointer past it; if
// every slot is marked the word reports full_res and nothing changes. cmd 1 clears all
// marks, cmd 2 invalidates every slot holding anim_number, cmd 3 does nothing; these return
// slot 0, hit 0, full_res 0. invalidated slots and all slots after reset hold animation 0,
// frame 0. every input word gives exactly one output word. a word goes through accept,
// parallel tag compare across all slots into registered hit vectors, then priority and
// circular free-slot search that updates the slot state and loads the output register. a new
// word is accepted while the previous result waits in the output register; the commit cycle
// waits only while that register is still held by out_stall.
module frame_slot_cache (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [fsc_pkg::CMD_W-1:0]      cmd,
	input  logic [fsc_pkg::TAG_W-1:0]      anim_number,
	input  logic [fsc_pkg::TAG_W-1:0]      frame_number,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [fsc_pkg::SLOT_OUT_W-1:0] slot,
	output logic                           hit,
	output logic                           full_res
);
	import fsc_pkg::*;

	// sequencing commands and datapath status
	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	// sequencer: accept, compare, commit
	fsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (dp_sts),
		.dp_cmd   (dp_cmd)
	);

	// tags, marks, pointer, search logic and output word register
	fsc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.dp_cmd       (dp_cmd),
		.sts          (dp_sts),
		.cmd          (cmd),
		.anim_number  (anim_number),
		.frame_number (frame_number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.slot         (slot),
		.hit          (hit),
		.full_res     (full_res)
	);

endmodule

### tb/slot_cache_checker.sv
module slot_cache_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [fsc_pkg::CMD_W-1:0]      cmd,
	input  logic [fsc_pkg::TAG_W-1:0]      anim_number,
	input  logic [fsc_pkg::TAG_W-1:0]      frame_number,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [fsc_pkg::SLOT_OUT_W-1:0] slot,
	input  logic                           hit,
	input  logic                           full_res,
	output int                             errors,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import fsc_pkg::*;

	typedef struct packed {
		logic [SLOT_OUT_W-1:0] slot;
		logic                  hit;
		logic                  full;
	} slot_word_t;

	logic [TAG_W-1:0] anim_tag  [SLOT_COUNT];
	logic [TAG_W-1:0] frame_tag [SLOT_COUNT];
	logic             marked    [SLOT_COUNT];
	int               rr_ptr;
	slot_word_t       expected_words [$];

	// updates the shadow cache and returns the word the block should answer with
	function automatic slot_word_t resolve_word(logic [CMD_W-1:0] c, logic [TAG_W-1:0] a,
			logic [TAG_W-1:0] f);
		slot_word_t w;
		int i;
		int s;
		bit done;
		w = '0;
		done = 1'b0;
		case (c)
		CMD_LOOKUP: begin
			for (i = 0; i < SLOT_COUNT && !done; i++) begin
				if (anim_tag[i] == a && frame_tag[i] == f) begin
					marked[i] = 1'b1;
					w.slot = SLOT_OUT_W'(i);
					w.hit = 1'b1;
					done = 1'b1;
				end
			end
			// miss: circular search for a free slot from the pointer
			for (i = 0; i < SLOT_COUNT && !done; i++) begin
				s = (rr_ptr + i) % SLOT_COUNT;
				if (!marked[s]) begin
					anim_tag[s] = a;
					frame_tag[s] = f;
					marked[s] = 1'b1;
					rr_ptr = (s + 1) % SLOT_COUNT;
					w.slot = SLOT_OUT_W'(s);
					done = 1'b1;
				end
			end
			if (!done)
				w.full = 1'b1;
		end
		CMD_CLEAR: begin
			for (i = 0; i < SLOT_COUNT; i++)
				marked[i] = 1'b0;
		end
		CMD_INVAL: begin
			for (i = 0; i < SLOT_COUNT; i++) begin
				if (anim_tag[i] == a) begin
					anim_tag[i] = '0;
					frame_tag[i] = '0;
					marked[i] = 1'b0;
				end
			end
		end
		default: ;
		endcase
		return w;
	endfunction

	task automatic report(string msg);
		if (errors < 100)
			$display("%0t slot_cache_checker: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		slot_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				anim_tag[i] = '0;
				frame_tag[i] = '0;
				marked[i] = 1'b0;
			end
			rr_ptr = 0;
			expected_words.delete();
			errors = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					report($sformatf("unexpected word slot %0d hit %0b full %0b",
						slot, hit, full_res));
				end else begin
					want = expected_words.pop_front();
					if (slot !== want.slot)
						report($sformatf("slot %0d, expected %0d", slot, want.slot));
					if (hit !== want.hit)
						report($sformatf("hit %0b, expected %0b", hit, want.hit));
					if (full_res !== want.full)
						report($sformatf("full_res %0b, expected %0b", full_res, want.full));
				end
			end
			if (in_valid && !in_stall)
				expected_words.push_back(resolve_word(cmd, anim_number, frame_number));
		end
		pending = expected_words.size();
	end

endmodule

### tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fsc_pkg::*;

	// cmd 3 has no name in the package: a do-nothing word
	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
	// cycles with no word moving on either side before the run is called hung
	localparam int HANG_LIMIT = 1000;
	// rough number of input words to send
	localparam int WORD_TARGET = 950;
	// words per random segment
	localparam int SEGMENT_LEN = 40;

	typedef enum {FILL_PHASE, MIX_PHASE} phase_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic [CMD_W-1:0]      cmd          = CMD_LOOKUP;
	logic [TAG_W-1:0]      anim_number  = '0;
	logic [TAG_W-1:0]      frame_number = '0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic [SLOT_OUT_W-1:0] slot;
	logic                  hit;
	logic                  full_res;

	int               errors;
	int               pending;
	int               words_sent  = 0;
	int               idle_cycles = 0;
	bit               send_gaps   = 1'b1;
	bit               recv_stalls = 1'b1;
	phase_t           phase;
	logic [TAG_W-1:0] anim_pool [4];
	int               pick;

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	frame_slot_cache dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.anim_number  (anim_number),
		.frame_number (frame_number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.slot         (slot),
		.hit          (hit),
		.full_res     (full_res)
	);

	// shadow cache and compare of every result word
	slot_cache_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.anim_number  (anim_number),
		.frame_number (frame_number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.slot         (slot),
		.hit          (hit),
		.full_res     (full_res),
		.errors       (errors),
		.pending      (pending)
	);

	function automatic logic [TAG_W-1:0] any_tag();
		return TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
	endfunction

	// drive one word at the falling edge, optionally after a gap, and hold it
	// until the block takes it at a rising edge
	task automatic send_word(logic [CMD_W-1:0] c, logic [TAG_W-1:0] a, logic [TAG_W-1:0] f);
		@(negedge clk);
		if (send_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		anim_number  <= a;
		frame_number <= f;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// receiver: random stall bursts while enabled
	initial begin
		forever begin
			@(negedge clk);
			if (recv_stalls && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	// hang detector: no word accepted on either side for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		// reset held, then released once
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed words
		// empty tag: animation 0 frame 0 hits cleared slot 0 right after reset
		send_word(CMD_LOOKUP, '0, '0);
		// all-ones tags miss and land on the slot after the hit one, then hit there
		send_word(CMD_LOOKUP, '1, '1);
		send_word(CMD_LOOKUP, '1, '1);
		// alternating bit patterns in both tags
		send_word(CMD_LOOKUP, 15'h5555, 15'h2aaa);
		send_word(CMD_LOOKUP, 15'h2aaa, 15'h5555);
		send_word(CMD_LOOKUP, '0, 15'd1);
		// do-nothing command with busy fields
		send_word(CMD_NOP, '1, '1);
		send_word(CMD_LOOKUP, '0, '0);
		// drop all marks, then invalidate the empty animation
		send_word(CMD_CLEAR, '1, '1);
		send_word(CMD_INVAL, '0, 15'h1234);
		send_word(CMD_LOOKUP, '0, '0);
		// invalidate the all-ones animation and allocate it again
		send_word(CMD_INVAL, '1, '0);
		send_word(CMD_LOOKUP, '1, '0);
		// invalidate an animation that is not cached
		send_word(CMD_INVAL, 15'h1234, '1);
		// hit on a slot whose mark was cleared
		send_word(CMD_LOOKUP, 15'h2aaa, 15'h5555);
		send_word(CMD_CLEAR, '0, '0);
		send_word(CMD_NOP, '0, '0);
		send_word(CMD_LOOKUP, 15'd1, '1);

		// random segments: fill phases send lookups that allocate slots and can fill the cache,
		// mix phases hit, clear and invalidate over a small set of animations
		while (words_sent < WORD_TARGET) begin
			phase = ($urandom_range(0, 2) == 0) ? FILL_PHASE : MIX_PHASE;
			for (int i = 0; i < 4; i++)
				anim_pool[i] = $urandom_range(0, 1) ? any_tag() : TAG_W'($urandom_range(0, 3));
			// last part of the run runs with no gaps or stalls
			if (words_sent >= WORD_TARGET - 2 * SEGMENT_LEN) begin
				send_gaps   = 1'b0;
				recv_stalls = 1'b0;
			end else begin
				send_gaps   = $urandom_range(0, 3) != 0;
				recv_stalls = $urandom_range(0, 3) != 0;
			end
			for (int k = 0; k < SEGMENT_LEN; k++) begin
				pick = $urandom_range(0, 99);
				if (phase == FILL_PHASE) begin
					if (pick < 90)
						send_word(CMD_LOOKUP, anim_pool[$urandom_range(0, 3)],
							TAG_W'($urandom_range(0, 63)));
					else
						send_word(CMD_LOOKUP, anim_pool[$urandom_range(0, 3)], any_tag());
				end else if (pick < 65) begin
					send_word(CMD_LOOKUP, anim_pool[$urandom_range(0, 3)],
						TAG_W'($urandom_range(0, 7)));
				end else if (pick < 72) begin
					send_word(CMD_LOOKUP, any_tag(), any_tag());
				end else if (pick < 82) begin
					send_word(CMD_CLEAR, any_tag(), any_tag());
				end else if (pick < 92) begin
					send_word(CMD_INVAL, anim_pool[$urandom_range(0, 3)], any_tag());
				end else if (pick < 95) begin
					send_word(CMD_INVAL, any_tag(), any_tag());
				end else begin
					send_word(CMD_NOP, any_tag(), any_tag());
				end
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		// drain, then a short quiet tail for any stray word
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

### sim.f
design/fsc_pkg.sv
design/fsc_ctrl.sv
design/fsc_dp.sv
design/frame_slot_cache.sv
tb/slot_cache_checker.sv
tb/tb_top.sv
